[hw/rtl/lcd1d_pkg.sv]
// ---------------------------------------------------------------------------
// lcd1d_pkg: shared types and constants of the linear charge deposit block
// Field widths, item structs, configuration register indexes and the
// fixed-point constants used by the deposit and readout datapaths.
// ---------------------------------------------------------------------------
package lcd1d_pkg;

  // Item field widths.
  localparam int POS_W  = 22;
  localparam int CHG_W  = 32;
  localparam int CELL_W = 6;
  localparam int DENS_W = 32;
  localparam int SUM_W  = 48;

  // Default grid size.
  localparam int NUM_CELLS_DEF = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_VOLUME    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_DENSITY = 1'b1;

  // Reset values of the configuration registers (1.0 and 0.0 in Q16.16).
  localparam logic [CFG_DATA_W-1:0] INV_CELL_VOLUME_RST    = 32'h0001_0000;
  localparam logic [CFG_DATA_W-1:0] BACKGROUND_DENSITY_RST = 32'h0000_0000;

  // Half a cell and half an LSB of Q16.16 after a Q16 product.
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // Input item.
  typedef struct packed {
    logic [POS_W-1:0]        cell_position;
    logic signed [CHG_W-1:0] charge;
    logic                    last_particle;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [CELL_W-1:0]        cell_index;
    logic signed [DENS_W-1:0] density;
    logic                     last_cell;
  } out_item_t;

endpackage

[hw/rtl/linear_charge_deposit_1d_top.sv]
// ---------------------------------------------------------------------------
// linear_charge_deposit_1d_top: one-dimensional linear charge deposition
// Deposits particle charge into a grid of cell accumulators with linear
// weights and reads out the scaled cell densities after the last particle.
// ---------------------------------------------------------------------------
// A particle is taken on start while busy is low: the cell store has one
// read and one write port, and each particle needs a read-modify-write of
// its left and of its right cell, one per cycle, so a new particle is taken
// in the cycle of the right-cell update. A particle marked last is deposited
// in the same way, after which busy stays high while NUM_CELLS results come
// out on consecutive cycles, dropping as the last one appears; each passes
// the registered steps of read, magnitude, two partial products, rounding
// and clamp, background add and saturation. Results carry out_valid for a
// single cycle each and cannot be held back, so the receiver must take them
// as they come. After reset the cell store reads as zero at once; there is
// no clearing pass. Configuration may be written whenever busy is low.
// ---------------------------------------------------------------------------
module linear_charge_deposit_1d_top
  import lcd1d_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // Result items
  output logic                  out_valid,
  output out_item_t             out_item,
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int RGT_W = POS_W - 15;
  localparam int PRD_W = SUM_W + 1;
  localparam int ADD_W = PRD_W - 16;

  typedef enum logic [1:0] {S_IDLE, S_DEP_L, S_DEP_R, S_READ} state_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0]        inv_vol_r;
  logic signed [CFG_DATA_W-1:0] bg_r;

  // Control state.
  state_t state_r, state_nxt;
  logic   accept;

  // Latched particle.
  logic signed [CHG_W-1:0] charge_r;
  logic [15:0]             frac_r;
  logic [IDX_W-1:0]        left_addr_r;
  logic [IDX_W-1:0]        right_addr_r;
  logic                    left_ok_r;
  logic                    right_ok_r;
  logic                    last_r;

  // Input decode.
  logic [POS_W:0]   pos_half;
  logic [RGT_W-1:0] right_in;
  logic [RGT_W-1:0] left_in;
  logic [15:0]      frac_in;
  logic [16:0]      wl_in;
  logic             left_ok_in;
  logic             right_ok_in;

  // Shared weight multiplier.
  logic signed [CHG_W-1:0] mul_a;
  logic signed [17:0]      mul_b;
  logic signed [49:0]      mul_p;
  logic signed [PRD_W-1:0] prod_r;

  // Cell store and its ports.
  logic [SUM_W-1:0] cell_mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] cell_vld_r;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [SUM_W-1:0] wdata;
  logic             mem_we;
  logic             byp;
  logic [SUM_W-1:0] rd_data_r;
  logic             rd_vld_r;

  // Deposit arithmetic.
  logic signed [PRD_W-1:0] prod_rnd;
  logic signed [ADD_W-1:0] dep_add;
  logic signed [SUM_W-1:0] old_sum;
  logic signed [SUM_W:0]   new_sum;

  // Readout pipeline.
  logic             iss_on_r;
  logic [IDX_W-1:0] iss_r;
  logic             p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic [IDX_W-1:0] p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r;
  logic             p1_last_r, p2_last_r, p3_last_r, p4_last_r;
  logic             p2_neg_r, p3_neg_r;
  logic [SUM_W-1:0] m_r;
  logic [63:0]      hi_r, lo_r;
  logic [63:0]      hi_nxt, lo_nxt;
  logic [63:0]      mag64;
  logic [33:0]      mag;
  logic signed [34:0] v_r;
  logic signed [35:0] dens_sum;
  logic signed [DENS_W-1:0] dens_sat;
  logic signed [SUM_W-1:0] rd_sum;

  out_item_t out_item_r;
  logic      out_valid_r;

  // Handshake: a particle is taken when idle or in the right-cell cycle of a
  // particle that does not start a readout.
  assign busy   = !((state_r == S_IDLE) || ((state_r == S_DEP_R) && !last_r));
  assign accept = start && !busy;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_vol_r <= INV_CELL_VOLUME_RST;
      bg_r      <= BACKGROUND_DENSITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_CELL_VOLUME:    inv_vol_r <= cfg_wdata;
        CFG_BACKGROUND_DENSITY: bg_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Split the position into the right cell and the fraction past its left edge.
  always_comb begin
    pos_half    = {1'b0, in_item.cell_position} + (POS_W+1)'(HALF_Q16);
    right_in    = pos_half[POS_W:16];
    frac_in     = pos_half[15:0];
    left_in     = right_in - RGT_W'(1);
    wl_in       = 17'h1_0000 - {1'b0, frac_in};
    left_ok_in  = (right_in != '0) && (right_in <= RGT_W'(NUM_CELLS));
    right_ok_in = right_in < RGT_W'(NUM_CELLS);
  end

  // One multiplier: left weight for a new particle, right weight otherwise.
  always_comb begin
    if (state_r == S_DEP_L) begin
      mul_a = charge_r;
      mul_b = signed'({2'b00, frac_r});
    end else begin
      mul_a = in_item.charge;
      mul_b = signed'({1'b0, wl_in});
    end
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p[PRD_W-1:0];
  end

  // Round the deposit to Q16.16 and add it to the old cell sum.
  always_comb begin
    prod_rnd = prod_r + PRD_W'(HALF_Q16);
    dep_add  = prod_rnd[PRD_W-1:16];
    old_sum  = rd_vld_r ? signed'(rd_data_r) : '0;
    new_sum  = (SUM_W+1)'(old_sum) + (SUM_W+1)'(dep_add);
    if (new_sum[SUM_W] != new_sum[SUM_W-1]) begin
      wdata = new_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      wdata = new_sum[SUM_W-1:0];
    end
  end

  // Store port selection.
  always_comb begin
    case (state_r)
      S_DEP_L: raddr = right_addr_r;
      S_READ:  raddr = iss_r;
      default: raddr = left_in[IDX_W-1:0];
    endcase
    waddr  = (state_r == S_DEP_L) ? left_addr_r : right_addr_r;
    mem_we = ((state_r == S_DEP_L) && left_ok_r) || ((state_r == S_DEP_R) && right_ok_r);
    byp    = mem_we && (waddr == raddr);
  end

  // Cell store: synchronous read with forwarding of a same-cycle write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[waddr] <= wdata;
    end
    rd_data_r <= byp ? wdata : cell_mem[raddr];
    rd_vld_r  <= byp || cell_vld_r[raddr];
  end

  // Written flags: a cell without one reads as zero; readout clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= '0;
    end else begin
      if (mem_we) begin
        cell_vld_r[waddr] <= 1'b1;
      end
      if ((state_r == S_READ) && iss_on_r) begin
        cell_vld_r[iss_r] <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DEP_L;
      end
      S_DEP_L: state_nxt = S_DEP_R;
      S_DEP_R: begin
        if (last_r)      state_nxt = S_READ;
        else if (accept) state_nxt = S_DEP_L;
        else             state_nxt = S_IDLE;
      end
      S_READ: begin
        if (p4_vld_r && p4_last_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, readout issue and pipeline valids, registered result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_on_r    <= 1'b0;
      iss_r       <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_r <= in_item.last_particle;
      end
      if ((state_r == S_DEP_R) && last_r) begin
        iss_on_r <= 1'b1;
        iss_r    <= '0;
      end else if ((state_r == S_READ) && iss_on_r) begin
        iss_r <= iss_r + IDX_W'(1);
        if (iss_r == IDX_W'(NUM_CELLS - 1)) iss_on_r <= 1'b0;
      end
      p1_vld_r    <= (state_r == S_READ) && iss_on_r;
      p2_vld_r    <= p1_vld_r;
      p3_vld_r    <= p2_vld_r;
      p4_vld_r    <= p3_vld_r;
      out_valid_r <= p4_vld_r;
    end
  end

  // Particle fields held for the two cell updates.
  always_ff @(posedge clk) begin
    if (accept) begin
      charge_r     <= in_item.charge;
      frac_r       <= frac_in;
      left_addr_r  <= left_in[IDX_W-1:0];
      right_addr_r <= right_in[IDX_W-1:0];
      left_ok_r    <= left_ok_in;
      right_ok_r   <= right_ok_in;
    end
  end

  // Readout arithmetic.
  always_comb begin
    rd_sum = rd_vld_r ? signed'(rd_data_r) : '0;
    hi_nxt = m_r * inv_vol_r[31:16];
    lo_nxt = m_r * inv_vol_r[15:0];
    mag64  = hi_r + ((lo_r + 64'(HALF_Q16)) >> 16);
    mag    = (mag64 > 64'h2_0000_0000) ? 34'h2_0000_0000 : mag64[33:0];
    dens_sum = 36'(v_r) + 36'(bg_r);
    if (dens_sum > 36'sh0_7FFF_FFFF) begin
      dens_sat = 32'sh7FFF_FFFF;
    end else if (dens_sum < -36'sh0_8000_0000) begin
      dens_sat = -32'sh8000_0000;
    end else begin
      dens_sat = dens_sum[DENS_W-1:0];
    end
  end

  // Readout stages: magnitude, partial products, rounding, background add.
  always_ff @(posedge clk) begin
    p1_idx_r  <= iss_r;
    p1_last_r <= iss_r == IDX_W'(NUM_CELLS - 1);

    p2_idx_r  <= p1_idx_r;
    p2_last_r <= p1_last_r;
    p2_neg_r  <= rd_sum[SUM_W-1];
    m_r       <= rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);

    p3_idx_r  <= p2_idx_r;
    p3_last_r <= p2_last_r;
    p3_neg_r  <= p2_neg_r;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;

    p4_idx_r  <= p3_idx_r;
    p4_last_r <= p3_last_r;
    v_r       <= p3_neg_r ? -signed'({1'b0, mag}) : signed'({1'b0, mag});

    out_item_r.cell_index <= CELL_W'(p4_idx_r);
    out_item_r.density    <= dens_sat;
    out_item_r.last_cell  <= p4_last_r;
  end

endmodule

[hw/rtl/lcd1d_checker.sv]
// ---------------------------------------------------------------------------
// lcd1d_checker: port-level checks of the linear charge deposit block
// Watches the readout run on the result ports against the input handshake.
// ---------------------------------------------------------------------------
module lcd1d_checker
  import lcd1d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input out_item_t out_item,
  input logic      out_valid
);

  // Every cell but the last one is reported while the block is busy.
  a_busy_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_cell |-> busy)
    else $error("result reported while the block takes items");

  // The readout run is unbroken and counts cells upward.
  a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_cell |=>
      out_valid && (out_item.cell_index == CELL_W'($past(out_item.cell_index) + 1'b1)))
    else $error("readout run broken or out of order");

  // The last cell ends the run.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_cell |=> !out_valid)
    else $error("result after the last cell");

  // A newly taken item never has a result in the cycle after it.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result straight after an accepted item");

endmodule

bind linear_charge_deposit_1d_top lcd1d_checker u_lcd1d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_item  (out_item),
  .out_valid (out_valid)
);

[tb/linear_charge_deposit_1d_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_charge_deposit_1d_top_tb: self-checking bench for the charge deposit
// Particles are driven through the start/busy handshake with random gaps and
// mirrored into a local deposit-and-readout predictor. Every cell density
// strobed out is checked field by field against the oldest predicted cell.
// A short table of directed particles and register writes comes first, and
// random phases under varied register settings follow.
// ---------------------------------------------------------------------------
module linear_charge_deposit_1d_top_tb;
  import lcd1d_pkg::*;

  localparam int     NUM_CELLS     = NUM_CELLS_DEF;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     IDLE_LIMIT    = 2000;
  localparam int     PHASES        = 6;
  localparam int     PHASE_ITEMS   = 35;
  localparam longint ACC_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN       = -ACC_MAX - 64'sd1;
  localparam longint DENS_MAX      = 64'sd2147483647;
  localparam longint DENS_MIN      = -64'sd2147483648;
  localparam longint MAG_CAP       = 64'sh0000_0002_0000_0000;
  localparam int unsigned ONE_WEIGHT = 32'h0001_0000;

  typedef enum bit {ROW_PARTICLE, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    in_item_t                 item;
    bit                       typed;
    logic [CELL_W-1:0]        typed_cell;
    logic [DENS_W-1:0]        typed_dens;
  } step_row_t;

  // DUT connections; the inputs are known from time zero.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Typed expectation travelling alongside the item it belongs to.
  bit                    typed_chk  = 1'b0;
  logic [CELL_W-1:0]     typed_cell = '0;
  logic [DENS_W-1:0]     typed_dens = '0;

  // Predictor state.
  logic [CFG_DATA_W-1:0]    vol_recip = INV_CELL_VOLUME_RST;
  logic signed [DENS_W-1:0] bg_level  = BACKGROUND_DENSITY_RST;
  logic signed [SUM_W-1:0]  cell_acc [NUM_CELLS];
  out_item_t                expected_cells [$];

  step_row_t dir_rows [$];
  int        n_errors    = 0;
  int        idle_cycles = 0;
  bit        rush        = 1'b0;

  linear_charge_deposit_1d_top #(
    .NUM_CELLS (NUM_CELLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Adds one weighted share of a charge to a cell, saturating at 48 bits.
  function automatic void add_share(int idx, logic signed [CHG_W-1:0] q, int unsigned w);
    longint prod;
    longint share;
    longint acc;
    if (idx < 0 || idx >= NUM_CELLS || w == 0) return;
    prod  = longint'(q) * longint'(w);
    share = (prod + 64'sd32768) >>> 16;
    acc   = longint'(cell_acc[idx]) + share;
    if (acc > ACC_MAX) acc = ACC_MAX;
    else if (acc < ACC_MIN) acc = ACC_MIN;
    cell_acc[idx] = acc[SUM_W-1:0];
  endfunction

  // Scales a cell sum by the reciprocal volume, rounding the magnitude half
  // away from zero, then adds the background and saturates to 32 bits.
  function automatic logic signed [DENS_W-1:0] cell_density(logic signed [SUM_W-1:0] acc);
    longint     a;
    logic [63:0] m;
    logic [63:0] mag;
    longint     v;
    a   = acc;
    m   = (a < 0) ? -a : a;
    mag = m * vol_recip[31:16] + ((m * vol_recip[15:0] + 64'h8000) >> 16);
    if (mag > MAG_CAP) mag = MAG_CAP;
    v = (a < 0) ? -longint'(mag) : longint'(mag);
    v = v + bg_level;
    if (v > DENS_MAX) v = DENS_MAX;
    else if (v < DENS_MIN) v = DENS_MIN;
    return v[DENS_W-1:0];
  endfunction

  // Deposits one particle into its two nearest cells and, on the last
  // particle, queues the whole grid readout and clears the sums.
  function automatic void deposit_particle(in_item_t it);
    logic [POS_W:0] s;
    int             right;
    int unsigned    frac;
    out_item_t      r;
    s     = {1'b0, it.cell_position} + (POS_W+1)'(HALF_Q16);
    right = int'(s[POS_W:16]);
    frac  = s[15:0];
    add_share(right - 1, it.charge, ONE_WEIGHT - frac);
    add_share(right, it.charge, frac);
    if (it.last_particle) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        r.cell_index = CELL_W'(i);
        r.density    = cell_density(cell_acc[i]);
        r.last_cell  = (i == NUM_CELLS - 1);
        expected_cells = {expected_cells, r};
        cell_acc[i] = '0;
      end
    end
  endfunction

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, int cell_no, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want)
      flag_error($sformatf("cell %0d %s expected %h got %h", cell_no, name, want, got));
  endfunction

  // Result checking, predictor register mirror and particle intake.
  always @(posedge clk) begin
    out_item_t want;
    int        k;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_cells.size() == 0) begin
          flag_error($sformatf("unexpected result for cell %0d", out_item.cell_index));
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_index", want.cell_index, 32'(want.cell_index),
                      32'(out_item.cell_index));
          check_field("density", want.cell_index, want.density, out_item.density);
          check_field("last_cell", want.cell_index, 32'(want.last_cell),
                      32'(out_item.last_cell));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_CELL_VOLUME:    vol_recip = cfg_wdata;
          CFG_BACKGROUND_DENSITY: bg_level  = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        deposit_particle(in_item);
        if (in_item.last_particle && typed_chk) begin
          k = expected_cells.size() - NUM_CELLS + int'(typed_cell);
          want = expected_cells[k];
          want.density = typed_dens;
          expected_cells[k] = want;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_particle(logic [POS_W-1:0] pos, logic [CHG_W-1:0] q,
                                       logic last, bit typed = 1'b0,
                                       logic [CELL_W-1:0] tgt_cell = '0,
                                       logic [DENS_W-1:0] dens = '0);
    step_row_t row;
    row.kind       = ROW_PARTICLE;
    row.reg_idx    = '0;
    row.reg_val    = '0;
    row.item.cell_position = pos;
    row.item.charge        = q;
    row.item.last_particle = last;
    row.typed      = typed;
    row.typed_cell = tgt_cell;
    row.typed_dens = dens;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_row_t row;
    row.kind       = ROW_CONFIG;
    row.reg_idx    = idx;
    row.reg_val    = val;
    row.item       = '0;
    row.typed      = 1'b0;
    row.typed_cell = '0;
    row.typed_dens = '0;
    dir_rows = {dir_rows, row};
  endfunction

  // Gap before the next item; runs of back-to-back items come and go.
  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) rush = !rush;
    return rush ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic in_item_t random_particle();
    in_item_t it;
    case ($urandom_range(0, 7))
      0:       it.cell_position = POS_W'($urandom_range(0, 32'h0001_8000));
      1:       it.cell_position = POS_W'($urandom_range(32'h003E_0000, 32'h003F_FFFF));
      default: it.cell_position = POS_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       it.charge = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2:    it.charge = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: it.charge = $urandom;
    endcase
    it.last_particle = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_volume();
    case ($urandom_range(0, 5))
      0:       return 32'h0001_0000;
      1, 2:    return $urandom_range(0, 32'h0002_0000);
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_background();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1, 2:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one particle and returns at the edge that takes it.
  task automatic send_particle(in_item_t it, int gap, bit typed = 1'b0,
                               logic [CELL_W-1:0] tgt_cell = '0,
                               logic [DENS_W-1:0] dens = '0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_item    <= it;
    typed_chk  <= typed;
    typed_cell <= tgt_cell;
    typed_dens <= dens;
    do @(posedge clk); while (busy);
  endtask

  // Waits until the readout is drained and the deposit pipeline has settled.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (busy || expected_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    step_row_t row;
    for (int i = 0; i < NUM_CELLS; i++) cell_acc[i] = '0;

    // After reset: a unit charge at the grid start puts half on cell 0;
    // the far corner loses the weight beyond the last cell.
    add_particle(22'h000000, 32'h0001_0000, 1'b1, 1'b1, 6'd0,  32'h0000_8000);
    add_particle(22'h3FFFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'd63, 32'h4000_7FFF);
    add_particle(22'h058000, 32'h8000_0000, 1'b1, 1'b1, 6'd5,  32'h8000_0000);
    // Mixed shares, ties on the deposit rounding and both grid edges.
    add_particle(22'h020000, 32'h0003_0000, 1'b0);
    add_particle(22'h01C000, 32'hFFFF_0000, 1'b0);
    add_particle(22'h000000, 32'hFFFF_FFFF, 1'b0);
    add_particle(22'h007FFF, 32'h0000_0001, 1'b0);
    add_particle(22'h3F8000, 32'h1234_5678, 1'b0);
    add_particle(22'h3F7FFF, 32'hFFFF_FF00, 1'b0);
    add_particle(22'h2AAAAA, 32'h5555_5555, 1'b1);
    // Half volume: readout ties round away from zero.
    add_config(CFG_INV_CELL_VOLUME,    32'h0000_8000);
    add_config(CFG_BACKGROUND_DENSITY, 32'h0000_0000);
    add_particle(22'h018000, 32'h0000_0001, 1'b0);
    add_particle(22'h028000, 32'hFFFF_FFFF, 1'b0);
    add_particle(22'h038000, 32'h0000_0003, 1'b1, 1'b1, 6'd2, 32'hFFFF_FFFF);
    // Largest volume and background: both ends of the output saturate.
    add_config(CFG_INV_CELL_VOLUME,    32'hFFFF_FFFF);
    add_config(CFG_BACKGROUND_DENSITY, 32'h7FFF_FFFF);
    add_particle(22'h0A8000, 32'h7FFF_FFFF, 1'b0);
    add_particle(22'h0B8000, 32'h8000_0000, 1'b1, 1'b1, 6'd11, 32'h8000_0000);
    // Zero volume with the lowest background: every cell reads the background.
    add_config(CFG_INV_CELL_VOLUME,    32'h0000_0000);
    add_config(CFG_BACKGROUND_DENSITY, 32'h8000_0000);
    add_particle(22'h070000, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'd7, 32'h8000_0000);
    add_config(CFG_INV_CELL_VOLUME,    INV_CELL_VOLUME_RST);
    add_config(CFG_BACKGROUND_DENSITY, BACKGROUND_DENSITY_RST);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_particle(row.item, draw_gap(), row.typed, row.typed_cell, row.typed_dens);
      end
    end

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_INV_CELL_VOLUME,    random_volume());
      write_reg(CFG_BACKGROUND_DENSITY, random_background());
      for (int n = 0; n < PHASE_ITEMS; n++) send_particle(random_particle(), draw_gap());
    end

    wait_idle();
    if (n_errors == 0 && expected_cells.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[linear_charge_deposit_1d_top.f]
hw/rtl/lcd1d_pkg.sv
hw/rtl/linear_charge_deposit_1d_top.sv
hw/rtl/lcd1d_checker.sv
tb/linear_charge_deposit_1d_top_tb.sv
